>>> sv/esgl_pkg.sv
// Package for the elevation smoother: controller states, result kind codes,
// register and accumulator widths. No dependencies.
package esgl_pkg;

	localparam int ACC_W = 40;
	localparam int MP_W = 5;
	localparam logic [MP_W-1:0] MP_RESET = 5'd9;

	localparam logic KIND_SAMPLE = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_UPD,
		ST_FL_STEP,
		ST_FL_SUB,
		ST_DIV,
		ST_EMIT,
		ST_ECHO_RD,
		ST_ECHO,
		ST_SUMM
	} esgl_state_t;

endpackage

>>> sv/esgl_ring.sv
// Sample ring memory: one write port, one read port with registered read data.
// No dependencies.
module esgl_ring #(
	parameter int DEPTH = 21,
	parameter int DW = 20,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];
	logic [DW-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> sv/esgl_div.sv
// Shift-subtract divider, one quotient bit per cycle, signed dividend,
// unsigned nonzero divisor, quotient truncated toward zero. No dependencies.
module esgl_div #(
	parameter int NW = 25,
	parameter int DW = 5,
	parameter int QW = 20
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic signed [NW-1:0] num,
	input  logic [DW-1:0]        den,
	output logic                 done,
	output logic signed [QW-1:0] quot
);

	localparam int SW = $clog2(NW + 1);

	logic [NW-1:0] a_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] den_q;
	logic          neg_q;
	logic          run_q;
	logic          done_q;
	logic [SW-1:0] step_q;

	logic [NW-1:0] num_mag;
	logic [DW:0]   rem_sh;
	logic [DW:0]   rem_dif;
	logic          ge;
	logic [QW-1:0] mag;

	always_comb begin
		num_mag = num[NW-1] ? -num : num;
		rem_sh = {rem_q, a_q[NW-1]};
		rem_dif = rem_sh - {1'b0, den_q};
		ge = (rem_sh >= {1'b0, den_q});
		mag = a_q[QW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				step_q <= SW'(NW);
			end else if (run_q) begin
				step_q <= step_q - SW'(1);
				if (step_q == SW'(1)) begin
					run_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= num_mag;
			rem_q <= '0;
			den_q <= den;
			neg_q <= num[NW-1];
		end else if (run_q) begin
			rem_q <= ge ? rem_dif[DW-1:0] : rem_sh[DW-1:0];
			a_q <= {a_q[NW-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = neg_q ? -mag : mag;

endmodule

>>> sv/esgl_stats.sv
// Track statistics: saturating ascent and descent sums, highest and lowest
// smoothed value. Uses esgl_pkg for the accumulator width.
module esgl_stats #(
	parameter int SB = 20
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            rec,
	input  logic                            clr,
	input  logic signed [SB-1:0]            v,
	output logic [esgl_pkg::ACC_W-1:0]      ascent,
	output logic [esgl_pkg::ACC_W-1:0]      descent,
	output logic signed [SB-1:0]            highest,
	output logic signed [SB-1:0]            lowest
);

	localparam int AW = esgl_pkg::ACC_W;

	logic [AW-1:0]        asc_q;
	logic [AW-1:0]        dsc_q;
	logic signed [SB-1:0] hi_q;
	logic signed [SB-1:0] lo_q;
	logic signed [SB-1:0] prev_q;
	logic                 has_prev_q;

	logic signed [SB:0] diff;
	logic               pos;
	logic [SB:0]        mag;
	logic [AW:0]        asc_sum;
	logic [AW:0]        dsc_sum;

	always_comb begin
		diff = (SB + 1)'(v) - (SB + 1)'(prev_q);
		pos = (diff > 0);
		mag = pos ? diff : -diff;
		asc_sum = {1'b0, asc_q} + (AW + 1)'(mag);
		dsc_sum = {1'b0, dsc_q} + (AW + 1)'(mag);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			asc_q <= '0;
			dsc_q <= '0;
			hi_q <= '0;
			lo_q <= '0;
			prev_q <= '0;
			has_prev_q <= 1'b0;
		end else if (clr) begin
			asc_q <= '0;
			dsc_q <= '0;
			hi_q <= '0;
			lo_q <= '0;
			prev_q <= '0;
			has_prev_q <= 1'b0;
		end else if (rec) begin
			prev_q <= v;
			if (has_prev_q) begin
				if (pos) begin
					asc_q <= asc_sum[AW] ? '1 : asc_sum[AW-1:0];
				end else begin
					dsc_q <= dsc_sum[AW] ? '1 : dsc_sum[AW-1:0];
				end
				if (v > hi_q) begin
					hi_q <= v;
				end
				if (v < lo_q) begin
					lo_q <= v;
				end
			end else begin
				hi_q <= v;
				lo_q <= v;
				has_prev_q <= 1'b1;
			end
		end
	end

	assign ascent = asc_q;
	assign descent = dsc_q;
	assign highest = hi_q;
	assign lowest = lo_q;

endmodule

>>> sv/elevation_smooth_gain_loss_top.sv
// Elevation smoother top level: controller, window sum and output register.
// Uses esgl_pkg, esgl_ring, esgl_div and esgl_stats.
//
// Input channel (in_valid/in_ready) takes one elevation sample per transaction,
// last_sample set on the final sample of a track. Output channel
// (out_valid/out_ready) gives smoothed samples, HALF_WINDOW samples late, and
// after the last one a summary transaction (kind set, end_of_run set) with
// ascent, descent, highest and lowest. Tracks shorter than both min_points and
// HALF_WINDOW + 1 samples are echoed raw with too_short set. cfg_we writes
// min_points from cfg_data. One item is worked at a time. A sample that
// yields a mean waits for the divider, which retires one quotient bit per
// cycle. The end of a track adds one divide per flushed sample, or one ring
// read per raw echo, plus one summary. The output register holds one result;
// a new sample is accepted while it waits, and the controller stalls only
// when it must load a result into a full register. Reset clears all track
// state and sets min_points to 9.
module elevation_smooth_gain_loss_top #(
	parameter int HALF_WINDOW = 10,
	parameter int SAMPLE_BITS = 20
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [esgl_pkg::MP_W-1:0]         cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic signed [SAMPLE_BITS-1:0]     elevation,
	input  logic                              last_sample,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              kind,
	output logic                              too_short,
	output logic signed [SAMPLE_BITS-1:0]     sample_value,
	output logic [esgl_pkg::ACC_W-1:0]        total_ascent,
	output logic [esgl_pkg::ACC_W-1:0]        total_descent,
	output logic signed [SAMPLE_BITS-1:0]     highest,
	output logic signed [SAMPLE_BITS-1:0]     lowest,
	output logic                              end_of_run
);

	localparam int SB = SAMPLE_BITS;
	localparam int WIN = 2 * HALF_WINDOW + 1;
	localparam int AW = $clog2(WIN);
	localparam int CW = $clog2(WIN + 1);
	localparam int SUM_W = SB + CW;
	localparam int BW = $clog2(HALF_WINDOW + 1);
	localparam int MW = (CW > esgl_pkg::MP_W) ? CW : esgl_pkg::MP_W;
	localparam int PW = CW + 1;
	localparam int ACC_W = esgl_pkg::ACC_W;

	esgl_pkg::esgl_state_t state_q, state_d;

	logic [esgl_pkg::MP_W-1:0] min_points_q;
	logic signed [SB-1:0]      elev_q;
	logic                      last_q;
	logic                      short_q;
	logic                      flush_q;
	logic [AW-1:0]             wr_pos_q;
	logic [CW-1:0]             seen_q;
	logic [CW-1:0]             cnt_q;
	logic [AW-1:0]             rd_q;
	logic [BW-1:0]             b_q;
	logic signed [SUM_W-1:0]   sum_q;

	logic                      out_valid_q;
	logic                      kind_q;
	logic                      too_short_q;
	logic signed [SB-1:0]      sample_value_q;
	logic [ACC_W-1:0]          total_ascent_q;
	logic [ACC_W-1:0]          total_descent_q;
	logic signed [SB-1:0]      highest_q;
	logic signed [SB-1:0]      lowest_q;
	logic                      end_of_run_q;

	logic [SB-1:0]             ring_rdata;
	logic                      ring_re;
	logic                      ring_we;
	logic [AW-1:0]             ring_raddr;

	logic                      div_start;
	logic signed [SUM_W-1:0]   div_num;
	logic [CW-1:0]             div_den;
	logic                      div_done;
	logic signed [SB-1:0]      div_quot;

	logic                      stats_rec;
	logic                      stats_clr;
	logic [ACC_W-1:0]          st_ascent;
	logic [ACC_W-1:0]          st_descent;
	logic signed [SB-1:0]      st_high;
	logic signed [SB-1:0]      st_low;

	logic                      load_smp;
	logic                      load_echo;
	logic                      load_sum;

	logic                      seen_sat;
	logic [CW-1:0]             seen_new;
	logic [AW-1:0]             wr_next;
	logic [AW-1:0]             rd_next;
	logic signed [SUM_W-1:0]   sum_new;
	logic                      short_new;
	logic                      main_new;
	logic [PW-1:0]             old_raw;
	logic [PW-1:0]             old_pos;
	logic [BW-1:0]             bmax;
	logic                      need_sub;
	logic                      slot_free;

	always_comb begin
		seen_sat = (seen_q == CW'(WIN));
		seen_new = seen_sat ? seen_q : seen_q + CW'(1);
		wr_next = (wr_pos_q == AW'(WIN - 1)) ? '0 : wr_pos_q + AW'(1);
		rd_next = (rd_q == AW'(WIN - 1)) ? '0 : rd_q + AW'(1);
		sum_new = sum_q - (seen_sat ? SUM_W'($signed(ring_rdata)) : '0) + SUM_W'(elev_q);
		short_new = last_q && (MW'(seen_new) < MW'(min_points_q))
			&& (seen_new < CW'(HALF_WINDOW + 1));
		main_new = !short_new && (seen_new >= CW'(HALF_WINDOW + 1));
		old_raw = PW'(wr_next) + PW'(WIN) - PW'(seen_new);
		old_pos = (old_raw >= PW'(WIN)) ? old_raw - PW'(WIN) : old_raw;
		bmax = (seen_new < CW'(HALF_WINDOW)) ? BW'(seen_new) : BW'(HALF_WINDOW);
		need_sub = (cnt_q > (CW'(b_q) + CW'(HALF_WINDOW)));
		slot_free = !out_valid_q || out_ready;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			esgl_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_d = esgl_pkg::ST_UPD;
				end
			end
			esgl_pkg::ST_UPD: begin
				if (main_new) begin
					state_d = esgl_pkg::ST_DIV;
				end else if (last_q) begin
					state_d = short_new ? esgl_pkg::ST_ECHO_RD : esgl_pkg::ST_FL_STEP;
				end else begin
					state_d = esgl_pkg::ST_IDLE;
				end
			end
			esgl_pkg::ST_FL_STEP: begin
				state_d = need_sub ? esgl_pkg::ST_FL_SUB : esgl_pkg::ST_DIV;
			end
			esgl_pkg::ST_FL_SUB: begin
				state_d = esgl_pkg::ST_FL_STEP;
			end
			esgl_pkg::ST_DIV: begin
				if (div_done) begin
					state_d = esgl_pkg::ST_EMIT;
				end
			end
			esgl_pkg::ST_EMIT: begin
				if (slot_free) begin
					if (flush_q) begin
						state_d = (b_q == BW'(1)) ? esgl_pkg::ST_SUMM : esgl_pkg::ST_FL_STEP;
					end else begin
						state_d = last_q ? esgl_pkg::ST_FL_STEP : esgl_pkg::ST_IDLE;
					end
				end
			end
			esgl_pkg::ST_ECHO_RD: begin
				state_d = esgl_pkg::ST_ECHO;
			end
			esgl_pkg::ST_ECHO: begin
				if (slot_free) begin
					state_d = (cnt_q == CW'(1)) ? esgl_pkg::ST_SUMM : esgl_pkg::ST_ECHO_RD;
				end
			end
			esgl_pkg::ST_SUMM: begin
				if (slot_free) begin
					state_d = esgl_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = esgl_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		ring_re = 1'b0;
		ring_we = 1'b0;
		ring_raddr = rd_q;
		div_start = 1'b0;
		div_num = sum_q;
		div_den = cnt_q;
		stats_rec = 1'b0;
		stats_clr = 1'b0;
		load_smp = 1'b0;
		load_echo = 1'b0;
		load_sum = 1'b0;
		case (state_q)
			esgl_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				ring_re = in_valid;
				ring_raddr = wr_pos_q;
			end
			esgl_pkg::ST_UPD: begin
				ring_we = 1'b1;
				div_start = main_new;
				div_num = sum_new;
				div_den = seen_new;
			end
			esgl_pkg::ST_FL_STEP: begin
				ring_re = need_sub;
				div_start = !need_sub;
			end
			esgl_pkg::ST_EMIT: begin
				stats_rec = slot_free;
				load_smp = slot_free;
			end
			esgl_pkg::ST_ECHO_RD: begin
				ring_re = 1'b1;
			end
			esgl_pkg::ST_ECHO: begin
				load_echo = slot_free;
			end
			esgl_pkg::ST_SUMM: begin
				stats_clr = slot_free;
				load_sum = slot_free;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= esgl_pkg::ST_IDLE;
			min_points_q <= esgl_pkg::MP_RESET;
			short_q <= 1'b0;
			flush_q <= 1'b0;
			wr_pos_q <= '0;
			seen_q <= '0;
			cnt_q <= '0;
			rd_q <= '0;
			b_q <= '0;
			sum_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				min_points_q <= cfg_data;
			end
			if (load_smp || load_echo || load_sum) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				esgl_pkg::ST_UPD: begin
					wr_pos_q <= wr_next;
					seen_q <= seen_new;
					sum_q <= sum_new;
					cnt_q <= seen_new;
					rd_q <= old_pos[AW-1:0];
					b_q <= bmax;
					short_q <= short_new;
					flush_q <= !main_new;
				end
				esgl_pkg::ST_FL_SUB: begin
					sum_q <= sum_q - SUM_W'($signed(ring_rdata));
					cnt_q <= cnt_q - CW'(1);
					rd_q <= rd_next;
				end
				esgl_pkg::ST_EMIT: begin
					if (slot_free) begin
						flush_q <= 1'b1;
						if (flush_q) begin
							b_q <= b_q - BW'(1);
						end
					end
				end
				esgl_pkg::ST_ECHO: begin
					if (slot_free) begin
						rd_q <= rd_next;
						cnt_q <= cnt_q - CW'(1);
					end
				end
				esgl_pkg::ST_SUMM: begin
					if (slot_free) begin
						wr_pos_q <= '0;
						seen_q <= '0;
						sum_q <= '0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			elev_q <= elevation;
			last_q <= last_sample;
		end
		if (load_smp || load_echo) begin
			kind_q <= esgl_pkg::KIND_SAMPLE;
			too_short_q <= load_echo;
			sample_value_q <= load_echo ? $signed(ring_rdata) : div_quot;
			total_ascent_q <= '0;
			total_descent_q <= '0;
			highest_q <= '0;
			lowest_q <= '0;
			end_of_run_q <= 1'b0;
		end else if (load_sum) begin
			kind_q <= esgl_pkg::KIND_SUMMARY;
			too_short_q <= short_q;
			sample_value_q <= '0;
			total_ascent_q <= short_q ? '0 : st_ascent;
			total_descent_q <= short_q ? '0 : st_descent;
			highest_q <= short_q ? '0 : st_high;
			lowest_q <= short_q ? '0 : st_low;
			end_of_run_q <= 1'b1;
		end
	end

	esgl_ring #(
		.DEPTH(WIN),
		.DW(SB)
	) u_ring (
		.clk(clk),
		.we(ring_we),
		.waddr(wr_pos_q),
		.wdata(elev_q),
		.re(ring_re),
		.raddr(ring_raddr),
		.rdata(ring_rdata)
	);

	esgl_div #(
		.NW(SUM_W),
		.DW(CW),
		.QW(SB)
	) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.num(div_num),
		.den(div_den),
		.done(div_done),
		.quot(div_quot)
	);

	esgl_stats #(
		.SB(SB)
	) u_stats (
		.clk(clk),
		.arst_n(arst_n),
		.rec(stats_rec),
		.clr(stats_clr),
		.v(div_quot),
		.ascent(st_ascent),
		.descent(st_descent),
		.highest(st_high),
		.lowest(st_low)
	);

	assign out_valid = out_valid_q;
	assign kind = kind_q;
	assign too_short = too_short_q;
	assign sample_value = sample_value_q;
	assign total_ascent = total_ascent_q;
	assign total_descent = total_descent_q;
	assign highest = highest_q;
	assign lowest = lowest_q;
	assign end_of_run = end_of_run_q;

endmodule

>>> sv/esgl_checker.sv
// Port-level checks for the elevation smoother, bound to the top level.
// Uses esgl_pkg for kind codes and accumulator width.
module esgl_checker #(
	parameter int SAMPLE_BITS = 20
) (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              out_valid,
	input logic                              out_ready,
	input logic                              kind,
	input logic                              too_short,
	input logic signed [SAMPLE_BITS-1:0]     sample_value,
	input logic [esgl_pkg::ACC_W-1:0]        total_ascent,
	input logic [esgl_pkg::ACC_W-1:0]        total_descent,
	input logic signed [SAMPLE_BITS-1:0]     highest,
	input logic signed [SAMPLE_BITS-1:0]     lowest,
	input logic                              end_of_run
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(sample_value)
			&& $stable(total_ascent) && $stable(end_of_run))
		else $error("result changed while stalled");

	a_end_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (end_of_run == (kind == esgl_pkg::KIND_SUMMARY)))
		else $error("end_of_run does not match summary kind");

	a_sample_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == esgl_pkg::KIND_SAMPLE |->
			total_ascent == '0 && total_descent == '0 && highest == '0 && lowest == '0)
		else $error("sample transaction carries summary fields");

	a_short_sum: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == esgl_pkg::KIND_SUMMARY && too_short |->
			total_ascent == '0 && total_descent == '0 && highest == '0 && lowest == '0)
		else $error("short track summary has nonzero totals");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == esgl_pkg::KIND_SUMMARY && !too_short |-> highest >= lowest)
		else $error("highest below lowest");

endmodule

bind elevation_smooth_gain_loss_top esgl_checker #(
	.SAMPLE_BITS(SAMPLE_BITS)
) u_esgl_checker (
	.clk(clk),
	.arst_n(arst_n),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.kind(kind),
	.too_short(too_short),
	.sample_value(sample_value),
	.total_ascent(total_ascent),
	.total_descent(total_descent),
	.highest(highest),
	.lowest(lowest),
	.end_of_run(end_of_run)
);

>>> dv/tb_elevation_smooth_gain_loss_top.sv
// Testbench for elevation_smooth_gain_loss_top: directed table, then random tracks.
// Depends on esgl_pkg and the top level; results are checked against a local
// predictor of the centered moving average, ascent/descent and min/max summary.
module tb_elevation_smooth_gain_loss_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int HALF = 10;
	localparam int SBITS = 20;
	localparam int WIN = 2 * HALF + 1;
	localparam int TRACK_ITEMS = 110;
	localparam int IDLE_LIMIT = 5000;
	localparam int SETTLE_CYCLES = 64;
	localparam int HOLD_CYCLES = 400;
	localparam int MAX_SHOWN = 10;
	localparam logic [SBITS-1:0] ELEV_MAX = 20'h7FFFF;
	localparam logic [SBITS-1:0] ELEV_MIN = 20'h80000;

	typedef enum logic [1:0] {
		EXP_MODEL,
		EXP_ECHO,
		EXP_SINGLE
	} exp_mode_t;

	typedef struct packed {
		logic                           is_cfg;
		logic [esgl_pkg::MP_W-1:0]      min_pts;
		logic [SBITS-1:0]               elev;
		logic                           is_last;
		exp_mode_t                      mode;
	} stim_row_t;

	typedef struct packed {
		logic                           kind;
		logic                           too_short;
		logic [SBITS-1:0]               sample_value;
		logic [esgl_pkg::ACC_W-1:0]     total_ascent;
		logic [esgl_pkg::ACC_W-1:0]     total_descent;
		logic [SBITS-1:0]               highest;
		logic [SBITS-1:0]               lowest;
		logic                           end_of_run;
	} track_result_t;

	localparam stim_row_t DIR_ROWS [24] = '{
		'{1'b0, 5'd0, ELEV_MAX, 1'b1, EXP_ECHO},
		'{1'b0, 5'd0, ELEV_MIN, 1'b1, EXP_ECHO},
		'{1'b0, 5'd0, 20'h00000, 1'b1, EXP_ECHO},
		'{1'b1, 5'd1, 20'h00000, 1'b0, EXP_MODEL},
		'{1'b0, 5'd0, 20'd12345, 1'b1, EXP_SINGLE},
		'{1'b0, 5'd0, 20'hFFFFF, 1'b1, EXP_SINGLE},
		'{1'b1, 5'd0, 20'h00000, 1'b0, EXP_MODEL},
		'{1'b0, 5'd0, ELEV_MIN, 1'b1, EXP_SINGLE},
		'{1'b1, 5'd31, 20'h00000, 1'b0, EXP_MODEL},
		'{1'b0, 5'd0, ELEV_MAX, 1'b0, EXP_MODEL},
		'{1'b0, 5'd0, ELEV_MIN, 1'b0, EXP_MODEL},
		'{1'b0, 5'd0, ELEV_MAX, 1'b0, EXP_MODEL},
		'{1'b0, 5'd0, ELEV_MIN, 1'b0, EXP_MODEL},
		'{1'b0, 5'd0, ELEV_MAX, 1'b0, EXP_MODEL},
		'{1'b0, 5'd0, ELEV_MIN, 1'b0, EXP_MODEL},
		'{1'b0, 5'd0, ELEV_MAX, 1'b0, EXP_MODEL},
		'{1'b0, 5'd0, ELEV_MIN, 1'b0, EXP_MODEL},
		'{1'b0, 5'd0, ELEV_MAX, 1'b0, EXP_MODEL},
		'{1'b0, 5'd0, ELEV_MIN, 1'b1, EXP_MODEL},
		'{1'b1, 5'd2, 20'h00000, 1'b0, EXP_MODEL},
		'{1'b0, 5'd0, ELEV_MAX, 1'b0, EXP_MODEL},
		'{1'b0, 5'd0, ELEV_MIN, 1'b0, EXP_MODEL},
		'{1'b0, 5'd0, ELEV_MAX, 1'b0, EXP_MODEL},
		'{1'b0, 5'd0, ELEV_MIN, 1'b1, EXP_MODEL}
	};

	logic                             clk = 1'b0;
	logic                             arst_n = 1'b0;
	logic                             cfg_we = 1'b0;
	logic [esgl_pkg::MP_W-1:0]        cfg_data = '0;
	logic                             in_valid = 1'b0;
	logic                             in_ready;
	logic signed [SBITS-1:0]          elevation = '0;
	logic                             last_sample = 1'b0;
	logic                             out_valid;
	logic                             out_ready = 1'b0;
	logic                             kind;
	logic                             too_short;
	logic signed [SBITS-1:0]          sample_value;
	logic [esgl_pkg::ACC_W-1:0]       total_ascent;
	logic [esgl_pkg::ACC_W-1:0]       total_descent;
	logic signed [SBITS-1:0]          highest;
	logic signed [SBITS-1:0]          lowest;
	logic                             end_of_run;

	longint                           ring_samples [WIN];
	longint                           window_total;
	int                               fill_count;
	int                               wr_idx;
	longint                           prev_smoothed;
	logic [esgl_pkg::ACC_W-1:0]       ascent_sum;
	logic [esgl_pkg::ACC_W-1:0]       descent_sum;
	longint                           high_mark;
	longint                           low_mark;
	bit                               seen_smoothed;
	logic [esgl_pkg::MP_W-1:0]        min_points_cfg = esgl_pkg::MP_RESET;

	track_result_t pending_results [$];
	track_result_t step_results [$];
	int            mismatches = 0;
	int            idle_cycles = 0;
	bit            tx_burst = 1'b0;
	bit            rx_burst = 1'b0;
	bit            hold_request = 1'b0;

	elevation_smooth_gain_loss_top #(
		.HALF_WINDOW(HALF),
		.SAMPLE_BITS(SBITS)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.elevation(elevation),
		.last_sample(last_sample),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.kind(kind),
		.too_short(too_short),
		.sample_value(sample_value),
		.total_ascent(total_ascent),
		.total_descent(total_descent),
		.highest(highest),
		.lowest(lowest),
		.end_of_run(end_of_run)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic track_result_t make_result(logic k, logic shrt, longint val,
			logic [esgl_pkg::ACC_W-1:0] asc, logic [esgl_pkg::ACC_W-1:0] desc,
			longint hi, longint lo, logic eor);
		track_result_t r;
		r.kind = k;
		r.too_short = shrt;
		r.sample_value = val[SBITS-1:0];
		r.total_ascent = asc;
		r.total_descent = desc;
		r.highest = hi[SBITS-1:0];
		r.lowest = lo[SBITS-1:0];
		r.end_of_run = eor;
		return r;
	endfunction

	function automatic string fmt_result(track_result_t r);
		return $sformatf("kind=%0d short=%0d value=%0d asc=%0d desc=%0d hi=%0d lo=%0d end=%0d",
			r.kind, r.too_short, $signed(r.sample_value), r.total_ascent, r.total_descent,
			$signed(r.highest), $signed(r.lowest), r.end_of_run);
	endfunction

	function automatic void reset_track();
		foreach (ring_samples[i])
			ring_samples[i] = 0;
		window_total = 0;
		fill_count = 0;
		wr_idx = 0;
		prev_smoothed = 0;
		ascent_sum = '0;
		descent_sum = '0;
		high_mark = 0;
		low_mark = 0;
		seen_smoothed = 1'b0;
	endfunction

	function automatic longint sample_back(int d);
		return ring_samples[(wr_idx + 2 * WIN - 1 - (d % WIN)) % WIN];
	endfunction

	function automatic logic [esgl_pkg::ACC_W-1:0] acc_add(logic [esgl_pkg::ACC_W-1:0] acc,
			longint v);
		logic [esgl_pkg::ACC_W:0] s;
		s = {1'b0, acc} + v[esgl_pkg::ACC_W:0];
		return s[esgl_pkg::ACC_W] ? {esgl_pkg::ACC_W{1'b1}} : s[esgl_pkg::ACC_W-1:0];
	endfunction

	function automatic void log_smoothed(longint v);
		longint diff;
		if (seen_smoothed) begin
			diff = v - prev_smoothed;
			if (diff > 0)
				ascent_sum = acc_add(ascent_sum, diff);
			else
				descent_sum = acc_add(descent_sum, -diff);
			if (v > high_mark)
				high_mark = v;
			if (v < low_mark)
				low_mark = v;
		end else begin
			high_mark = v;
			low_mark = v;
			seen_smoothed = 1'b1;
		end
		prev_smoothed = v;
	endfunction

	function automatic void predict_sample(logic signed [SBITS-1:0] e, logic is_last);
		longint x;
		longint v;
		longint s;
		int     m;
		int     min_eff;
		int     bmax;
		int     top;
		int     b;
		int     d;
		bit     shrt;
		x = e;
		if (fill_count >= WIN)
			window_total -= ring_samples[wr_idx];
		ring_samples[wr_idx] = x;
		wr_idx = (wr_idx + 1) % WIN;
		window_total += x;
		if (fill_count < WIN)
			fill_count++;
		m = fill_count;
		min_eff = (min_points_cfg < HALF + 1) ? int'(min_points_cfg) : HALF + 1;
		shrt = is_last && (m < min_eff);
		if (!shrt && m >= HALF + 1) begin
			v = window_total / m;
			log_smoothed(v);
			step_results.push_back(make_result(esgl_pkg::KIND_SAMPLE, 1'b0, v, '0, '0, 0, 0,
				1'b0));
		end
		if (is_last) begin
			if (shrt) begin
				for (d = m; d > 0; d--)
					step_results.push_back(make_result(esgl_pkg::KIND_SAMPLE, 1'b1,
						sample_back(d - 1), '0, '0, 0, 0, 1'b0));
				step_results.push_back(make_result(esgl_pkg::KIND_SUMMARY, 1'b1, 0, '0, '0, 0, 0,
					1'b1));
			end else begin
				bmax = (m < HALF) ? m : HALF;
				for (b = bmax; b > 0; b--) begin
					top = b - 1 + HALF;
					if (top > m - 1)
						top = m - 1;
					s = 0;
					for (d = 0; d <= top; d++)
						s += sample_back(d);
					v = s / (top + 1);
					log_smoothed(v);
					step_results.push_back(make_result(esgl_pkg::KIND_SAMPLE, 1'b0, v, '0, '0,
						0, 0, 1'b0));
				end
				step_results.push_back(make_result(esgl_pkg::KIND_SUMMARY, 1'b0, 0, ascent_sum,
					descent_sum, high_mark, low_mark, 1'b1));
			end
			reset_track();
		end
	endfunction

	task automatic send_sample(logic [SBITS-1:0] e, logic is_last, exp_mode_t mode);
		int     gap;
		longint x;
		gap = tx_burst ? 0 : $urandom_range(0, 16);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		elevation <= e;
		last_sample <= is_last;
		do
			@(posedge clk);
		while (!in_ready);
		x = longint'($signed(e));
		step_results.delete();
		predict_sample(e, is_last);
		case (mode)
			EXP_ECHO: begin
				pending_results.push_back(make_result(esgl_pkg::KIND_SAMPLE, 1'b1, x, '0, '0,
					0, 0, 1'b0));
				pending_results.push_back(make_result(esgl_pkg::KIND_SUMMARY, 1'b1, 0, '0, '0,
					0, 0, 1'b1));
			end
			EXP_SINGLE: begin
				pending_results.push_back(make_result(esgl_pkg::KIND_SAMPLE, 1'b0, x, '0, '0,
					0, 0, 1'b0));
				pending_results.push_back(make_result(esgl_pkg::KIND_SUMMARY, 1'b0, 0, '0, '0,
					x, x, 1'b1));
			end
			default: begin
				foreach (step_results[i])
					pending_results.push_back(step_results[i]);
			end
		endcase
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_min_points(logic [esgl_pkg::MP_W-1:0] v);
		settle();
		cfg_we <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		min_points_cfg = v;
	endtask

	initial begin
		int                          n;
		int                          len;
		int                          style;
		int                          rnd_items;
		bit                          first_track;
		longint                      level;
		logic [SBITS-1:0]            e;
		logic [esgl_pkg::MP_W-1:0]   mp;
		reset_track();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIR_ROWS[i]) begin
			if (DIR_ROWS[i].is_cfg)
				write_min_points(DIR_ROWS[i].min_pts);
			else
				send_sample(DIR_ROWS[i].elev, DIR_ROWS[i].is_last, DIR_ROWS[i].mode);
		end

		hold_request = 1'b1;
		tx_burst = 1'b1;
		rnd_items = 0;
		first_track = 1'b1;
		while (rnd_items < TRACK_ITEMS) begin
			if (!first_track && $urandom_range(0, 2) == 0) begin
				case ($urandom_range(0, 8))
					0: mp = 5'd0;
					1: mp = 5'd1;
					2: mp = 5'd2;
					3: mp = esgl_pkg::MP_RESET;
					4: mp = 5'd10;
					5: mp = 5'd11;
					6: mp = 5'd12;
					7: mp = 5'd31;
					default: mp = esgl_pkg::MP_W'($urandom_range(0, 31));
				endcase
				write_min_points(mp);
			end
			if (first_track)
				len = 28;
			else if ($urandom_range(0, 3) == 0)
				len = $urandom_range(15, 30);
			else
				len = $urandom_range(1, 14);
			if (!first_track)
				tx_burst = ($urandom_range(0, 3) == 0);
			style = $urandom_range(0, 2);
			level = longint'($urandom_range(0, 20'hFFFFF)) - 524288;
			for (n = 0; n < len; n++) begin
				case (style)
					0: e = SBITS'($urandom());
					1: begin
						level += longint'($urandom_range(0, 128)) - 64;
						if (level > 524287)
							level = 524287;
						if (level < -524288)
							level = -524288;
						e = level[SBITS-1:0];
					end
					default: begin
						case ($urandom_range(0, 2))
							0: e = ELEV_MAX;
							1: e = ELEV_MIN;
							default: e = SBITS'($urandom());
						endcase
					end
				endcase
				send_sample(e, n == len - 1, EXP_MODEL);
			end
			rnd_items += len;
			first_track = 1'b0;
		end

		settle();
		if (mismatches == 0 && pending_results.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	initial begin
		int stall;
		int taken;
		taken = 0;
		while (!arst_n)
			@(posedge clk);
		forever begin
			if (hold_request) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_request = 1'b0;
			end
			stall = rx_burst ? 0 : $urandom_range(0, 16);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do
				@(posedge clk);
			while (!out_valid);
			taken++;
			if (taken % 16 == 0)
				rx_burst = ($urandom_range(0, 2) == 0);
		end
	end

	always @(posedge clk) begin
		track_result_t got;
		track_result_t want;
		if (arst_n && out_valid && out_ready) begin
			got = make_result(kind, too_short, longint'(sample_value), total_ascent,
				total_descent, longint'(highest), longint'(lowest), end_of_run);
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_SHOWN)
					$display("%0t: result with nothing expected: %s", $realtime, fmt_result(got));
			end else begin
				want = pending_results.pop_front();
				if (got.kind !== want.kind || got.too_short !== want.too_short ||
						got.sample_value !== want.sample_value ||
						got.total_ascent !== want.total_ascent ||
						got.total_descent !== want.total_descent ||
						got.highest !== want.highest || got.lowest !== want.lowest ||
						got.end_of_run !== want.end_of_run) begin
					mismatches++;
					if (mismatches <= MAX_SHOWN)
						$display("%0t: mismatch\n  expected %s\n  actual   %s", $realtime,
							fmt_result(want), fmt_result(got));
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles == IDLE_LIMIT) begin
			$display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
			$display("FAILED: results differ");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

endmodule
